FILE: sv/dlmcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlmcf_pkg;

  localparam int NUM_PEDALS = 10;
  localparam int NUM_MISC   = 13;
  // Pedals take slots 0..9, misc lights 10..22, the display slot 23.
  localparam int NUM_SLOTS  = NUM_PEDALS + NUM_MISC + 1;
  localparam int NUM_LAMPS  = NUM_PEDALS + NUM_MISC;

  localparam logic [4:0] DISPLAY_SLOT = 5'd23;
  localparam logic [4:0] PEDAL_NINE   = 5'd9;
  localparam logic [4:0] MISC_BASE    = 5'd10;

  // Slots that emit a transaction when dirty: misc lights 0, 1, 2 and 5 are silent.
  localparam logic [NUM_SLOTS-1:0] EMIT_MASK = 24'hFF63FF;

  localparam logic [6:0] CC_LAMP_ON  = 7'd106;
  localparam logic [6:0] CC_LAMP_OFF = 7'd107;
  localparam logic [6:0] CC_DISPLAY  = 7'd108;

  // Input operation codes.
  localparam logic [2:0] OP_SET_PEDAL = 3'd0;
  localparam logic [2:0] OP_SET_MISC  = 3'd1;
  localparam logic [2:0] OP_SET_DIGIT = 3'd2;
  localparam logic [2:0] OP_MARK_ALL  = 3'd3;
  localparam logic [2:0] OP_FLUSH     = 3'd4;

  // Command kinds between front and back.
  localparam logic [1:0] KIND_SET_LAMP  = 2'd0;
  localparam logic [1:0] KIND_SET_DIGIT = 2'd1;
  localparam logic [1:0] KIND_MARK_ALL  = 2'd2;
  localparam logic [1:0] KIND_FLUSH     = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] slot;
    logic       light_on;
    logic [6:0] digits_value;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/dlmcf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dlmcf_front
  import dlmcf_pkg::*;
(
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,
  input  wire logic [15:0] in_tdata,
  input  wire logic        q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  logic [3:0] index;
  logic       keep;

  assign index     = in_tdata[3:0];
  assign in_tready = !q_full;

  always_comb begin
    q_cmd.kind         = KIND_SET_LAMP;
    q_cmd.slot         = {1'b0, index};
    q_cmd.light_on     = in_tdata[4];
    q_cmd.digits_value = in_tdata[11:5];
    keep               = 1'b0;
    case (in_tuser)
      OP_SET_PEDAL: begin
        keep = (index < 4'(NUM_PEDALS));
      end
      OP_SET_MISC: begin
        q_cmd.slot = {1'b0, index} + MISC_BASE;
        keep       = (index < 4'(NUM_MISC));
      end
      OP_SET_DIGIT: begin
        q_cmd.kind = KIND_SET_DIGIT;
        keep       = 1'b1;
      end
      OP_MARK_ALL: begin
        q_cmd.kind = KIND_MARK_ALL;
        keep       = 1'b1;
      end
      OP_FLUSH: begin
        q_cmd.kind = KIND_FLUSH;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Ignored operations are accepted and dropped here.
  assign q_push = in_tvalid && in_tready && keep;

endmodule

`default_nettype wire

FILE: sv/dlmcf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dlmcf_queue
  import dlmcf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dlmcf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dlmcf_back
  import dlmcf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire cmd_t        q_cmd,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);

  logic [NUM_LAMPS-1:0] lamp_r, lamp_nxt;
  logic [NUM_SLOTS-1:0] dirty_r, dirty_nxt;
  logic [NUM_SLOTS-1:0] pend_r, pend_nxt;
  logic [6:0]           disp_r, disp_nxt;
  logic                 out_valid_r;
  logic [6:0]           out_ctrl_r, out_val_r;
  logic                 out_last_r;

  logic [NUM_SLOTS-1:0] sel;
  logic [4:0]           sel_slot;
  logic                 load;
  logic [6:0]           ctrl_nxt, val_nxt;

  // A flush holds off the queue until its snapshot of pending slots is drained.
  assign q_pop = q_valid && (pend_r == '0);
  assign load  = (pend_r != '0) && (!out_valid_r || out_tready);

  // Lowest pending slot goes out first.
  assign sel = pend_r & (~pend_r + 1'b1);

  always_comb begin
    sel_slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        sel_slot = 5'(i);
      end
    end
  end

  always_comb begin
    if (sel_slot == DISPLAY_SLOT) begin
      ctrl_nxt = CC_DISPLAY;
      val_nxt  = disp_r;
    end else begin
      ctrl_nxt = lamp_r[sel_slot] ? CC_LAMP_ON : CC_LAMP_OFF;
      // Misc light i sits at slot i+10, so slot+1 gives i+11 as well.
      val_nxt  = (sel_slot == PEDAL_NINE) ? 7'd0 : {2'b00, sel_slot} + 7'd1;
    end
  end

  always_comb begin
    lamp_nxt  = lamp_r;
    dirty_nxt = dirty_r;
    disp_nxt  = disp_r;
    pend_nxt  = pend_r;
    if (load) begin
      pend_nxt = pend_r & ~sel;
    end
    if (q_pop) begin
      case (q_cmd.kind)
        KIND_SET_LAMP: begin
          if (lamp_r[q_cmd.slot] != q_cmd.light_on) begin
            lamp_nxt[q_cmd.slot]  = q_cmd.light_on;
            dirty_nxt[q_cmd.slot] = 1'b1;
          end
        end
        KIND_SET_DIGIT: begin
          if (disp_r != q_cmd.digits_value) begin
            disp_nxt                = q_cmd.digits_value;
            dirty_nxt[DISPLAY_SLOT] = 1'b1;
          end
        end
        KIND_MARK_ALL: begin
          dirty_nxt = '1;
        end
        KIND_FLUSH: begin
          pend_nxt  = dirty_r & EMIT_MASK;
          dirty_nxt = '0;
        end
        default: begin
          dirty_nxt = dirty_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_r      <= '0;
      dirty_r     <= '0;
      disp_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      lamp_r  <= lamp_nxt;
      dirty_r <= dirty_nxt;
      disp_r  <= disp_nxt;
      pend_r  <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ctrl_r <= ctrl_nxt;
      out_val_r  <= val_nxt;
      out_last_r <= ((pend_r & ~sel) == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_ctrl_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: sv/dirty_light_midi_cc_flush_top.sv
// Channel   | Direction | Contents
// in_       | slave     | tuser: operation; tdata: index, light_on, digits_value
// out_      | master    | tdata: cc_controller, cc_value; tlast: final event of a flush
//
// Set and mark-all transactions are taken one per cycle unless the queue is full and
// retire one per cycle from the queue unless a flush drains. A flush snapshots the
// dirty marks, then emits an event per non-silent dirty slot (up to 20); the back end
// takes no other command until the snapshot drains. The queue keeps in_tready high
// meanwhile until it is full. Reset is synchronous, active low, and clears all lamps,
// marks and the display. A stalled output holds its event; the back end waits on it.
`timescale 1ns / 1ps
`default_nettype none

module dirty_light_midi_cc_flush_top
  import dlmcf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [2:0]  in_tuser,   // operation
  input  wire logic [15:0] in_tdata,   // index[3:0], light_on[4], digits_value[11:5]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // cc_controller[6:0], cc_value[13:7]
  output logic             out_tlast
);

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  dlmcf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  dlmcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  dlmcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: sv/dlmcf_check.sv
`timescale 1ns / 1ps
`default_nettype none

module dlmcf_check
  import dlmcf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ctrl_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] == CC_LAMP_ON || out_tdata[6:0] == CC_LAMP_OFF ||
                    out_tdata[6:0] == CC_DISPLAY))
    else $error("bad controller number");

  // The display is walked last, so its event always closes a flush.
  a_display_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:0] == CC_DISPLAY |-> out_tlast)
    else $error("display event not final");

  // Lamp codes run from 0 to 23 only.
  a_lamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:0] != CC_DISPLAY |-> out_tdata[13:7] <= 7'd23)
    else $error("lamp code out of range");

endmodule

bind dirty_light_midi_cc_flush_top dlmcf_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
